// File: src/tach_pkg.sv
// Shared types and constants for the tachometer speed meter.
package tach_pkg;

    localparam int RPM_W    = 29;
    localparam int RAW_W    = 32;
    localparam int PPR_W    = 8;
    localparam int WIN_W    = 24;
    localparam int EDGE_W   = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    // Divider operand widths: the window numerator is a 24-bit count times 6e9.
    localparam int NUM_W = 57;
    localparam int DEN_W = 40;
    localparam int QUO_W = RPM_W;
    localparam int SH_W  = DEN_W + QUO_W;
    localparam int CNT_W = 5;

    localparam logic [RPM_W-1:0]  RPM_MAX    = 29'd300000000;
    localparam logic [32:0]       RPM_SCALE  = 33'd6000000000;
    // 6e9 = 5859375 * 2^10, which keeps the window product narrow.
    localparam logic [22:0]       WIN_MULT   = 23'd5859375;
    localparam int                WIN_SHIFT  = 10;
    localparam logic [EDGE_W-1:0] EDGE_MAX   = 24'hFFFFFF;
    localparam logic [PPR_W-1:0]  PPR_RESET  = 8'd20;
    localparam logic [WIN_W-1:0]  WIN_RESET  = 24'd500000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 2'd0,
        CFG_PPR    = 2'd1,
        CFG_WINDOW = 2'd2
    } cfg_index_t;

    typedef enum logic {
        MODE_PERIOD = 1'b0,
        MODE_WINDOW = 1'b1
    } measure_mode_t;

    typedef struct packed {
        measure_mode_t          measure_mode;
        logic [PPR_W-1:0]       pulses_per_rev;
        logic [WIN_W-1:0]       window_us;
    } cfg_t;

    typedef struct packed {
        measure_mode_t          mode;
        logic [RAW_W-1:0]       raw;
    } job_t;

    typedef struct packed {
        logic                   full;
        logic                   valid;
    } queue_stat_t;

endpackage

// File: src/tach_ifs.sv
// Channel interfaces for ticks, speed results and register writes.
interface tach_tick_if
    import tach_pkg::*;
();
    logic valid;
    logic ready;
    logic sensor_level;

    modport source (output valid, output sensor_level, input ready);
    modport sink (input valid, input sensor_level, output ready);
endinterface

interface tach_result_if
    import tach_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [RPM_W-1:0] rpm_hundredths;
    logic [RAW_W-1:0] raw_measure;

    modport source (output valid, output rpm_hundredths, output raw_measure, input ready);
    modport sink (input valid, input rpm_hundredths, input raw_measure, output ready);
endinterface

interface tach_cfg_if
    import tach_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/tach_front.sv
// Edge detection, period and window counting; emits one division job per result.
module tach_front
    import tach_pkg::*;
#(
    parameter int COUNTER_WIDTH = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic accept,
    input  logic sensor_level,
    output logic job_valid,
    output job_t job
);

    logic                     prev_level_reg, prev_level_next;
    logic [COUNTER_WIDTH-1:0] period_reg, period_next;
    logic [EDGE_W-1:0]        edge_count_reg, edge_count_next;
    logic [WIN_W-1:0]         window_ticks_reg, window_ticks_next;

    logic                     rise;
    logic [COUNTER_WIDTH-1:0] period_sat;
    logic [WIN_W-1:0]         win_eff;
    logic [EDGE_W-1:0]        edges_inc;
    logic [WIN_W-1:0]         ticks_inc;
    logic                     window_close;

    always_comb
    begin
        rise       = sensor_level & ~prev_level_reg;
        period_sat = (period_reg == '1) ? period_reg : period_reg + 1'b1;
        win_eff    = (cfg.window_us == '0) ? WIN_W'(1) : cfg.window_us;
        edges_inc  = (rise && (edge_count_reg != EDGE_MAX)) ? edge_count_reg + 1'b1
                                                            : edge_count_reg;
        ticks_inc  = (window_ticks_reg != EDGE_MAX) ? window_ticks_reg + 1'b1
                                                    : window_ticks_reg;
        window_close = (ticks_inc >= win_eff);

        prev_level_next   = prev_level_reg;
        period_next       = period_reg;
        edge_count_next   = edge_count_reg;
        window_ticks_next = window_ticks_reg;
        job_valid         = 1'b0;
        job.mode          = cfg.measure_mode;
        job.raw           = '0;

        if (accept)
        begin
            prev_level_next = sensor_level;
            period_next     = rise ? '0 : period_sat;
            if (cfg.measure_mode == MODE_PERIOD)
            begin
                edge_count_next   = '0;
                window_ticks_next = '0;
                job_valid         = rise;
                job.raw           = RAW_W'(period_sat);
            end
            else if (window_close)
            begin
                job_valid         = 1'b1;
                job.raw           = RAW_W'(edges_inc);
                edge_count_next   = '0;
                window_ticks_next = '0;
            end
            else
            begin
                edge_count_next   = edges_inc;
                window_ticks_next = ticks_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg   <= 1'b0;
            period_reg       <= '0;
            edge_count_reg   <= '0;
            window_ticks_reg <= '0;
        end
        else
        begin
            prev_level_reg   <= prev_level_next;
            period_reg       <= period_next;
            edge_count_reg   <= edge_count_next;
            window_ticks_reg <= window_ticks_next;
        end
    end

endmodule

// File: src/tach_queue.sv
// Two-entry job queue between the counting front and the divider back.
module tach_queue
    import tach_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  job_t        push_job,
    input  logic        pop,
    output job_t        pop_job,
    output queue_stat_t stat
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
        stat.full   = (count_reg == 2'd2);
        stat.valid  = (count_reg != 2'd0);
        pop_job     = slot_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: src/tach_back.sv
// Speed computation: operand set-up, radix-2 restoring divide, clamp and output register.
module tach_back
    import tach_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  queue_stat_t      q_stat,
    input  job_t             q_job,
    output logic             pop,
    output logic             result_valid,
    input  logic             result_ready,
    output logic [RPM_W-1:0] rpm_hundredths,
    output logic [RAW_W-1:0] raw_measure
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_CHECK,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t            state_reg, state_next;
    job_t              job_reg, job_next;
    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [SH_W-1:0]   den_sh_reg, den_sh_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              res_valid_reg, res_valid_next;
    logic [RPM_W-1:0]  rpm_reg, rpm_next;
    logic [RAW_W-1:0]  raw_reg, raw_next;

    logic [PPR_W-1:0]  ppr_eff;
    logic [WIN_W-1:0]  win_eff;
    logic              q_bit;

    always_comb
    begin
        ppr_eff = (cfg.pulses_per_rev == '0) ? PPR_W'(1) : cfg.pulses_per_rev;
        win_eff = (cfg.window_us == '0) ? WIN_W'(1) : cfg.window_us;
        q_bit   = (SH_W'(rem_reg) >= den_sh_reg);

        state_next     = state_reg;
        job_next       = job_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        den_sh_next    = den_sh_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        rpm_next       = rpm_reg;
        raw_next       = raw_reg;
        pop            = 1'b0;
        res_valid_next = res_valid_reg && !result_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_stat.valid)
                begin
                    pop        = 1'b1;
                    job_next   = q_job;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (job_reg.mode == MODE_PERIOD)
                begin
                    rem_next = NUM_W'(RPM_SCALE);
                    den_next = DEN_W'(job_reg.raw) * DEN_W'(ppr_eff);
                end
                else
                begin
                    rem_next = NUM_W'(NUM_W'(job_reg.raw[EDGE_W-1:0]) * NUM_W'(WIN_MULT))
                               << WIN_SHIFT;
                    den_next = DEN_W'(ppr_eff) * DEN_W'(win_eff);
                end
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                // A quotient of 2^29 or more is past the clamp; skip the divide.
                if (SH_W'(rem_reg) >= (SH_W'(den_reg) << QUO_W))
                begin
                    quo_next   = RPM_MAX;
                    state_next = ST_FINISH;
                end
                else
                begin
                    den_sh_next = SH_W'(den_reg) << (QUO_W - 1);
                    quo_next    = '0;
                    cnt_next    = CNT_W'(QUO_W - 1);
                    state_next  = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (q_bit)
                begin
                    rem_next = rem_reg - den_sh_reg[NUM_W-1:0];
                end
                quo_next    = {quo_reg[QUO_W-2:0], q_bit};
                den_sh_next = den_sh_reg >> 1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!res_valid_reg || result_ready)
                begin
                    rpm_next       = (quo_reg > RPM_MAX) ? RPM_MAX : quo_reg;
                    raw_next       = job_reg.raw;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            job_reg       <= '0;
            rem_reg       <= '0;
            den_reg       <= '0;
            den_sh_reg    <= '0;
            quo_reg       <= '0;
            cnt_reg       <= '0;
            rpm_reg       <= '0;
            raw_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            job_reg       <= job_next;
            rem_reg       <= rem_next;
            den_reg       <= den_next;
            den_sh_reg    <= den_sh_next;
            quo_reg       <= quo_next;
            cnt_reg       <= cnt_next;
            rpm_reg       <= rpm_next;
            raw_reg       <= raw_next;
        end
    end

    assign result_valid   = res_valid_reg;
    assign rpm_hundredths = rpm_reg;
    assign raw_measure    = raw_reg;

endmodule

// File: src/tachometer_period_and_window_count.sv
// Flow: a tick is accepted whenever the two-entry queue has room; each result occupies the
// back end through pop, set-up, range check, the quotient bits one by one and output load,
// or through pop, set-up, range check and output load when the range check skips the divide,
// plus any wait on result ready. The next job is not popped until that result is loaded.
// Reset: asynchronous active-low; counters clear, registers return to mode 0, 20 pulses
// per revolution and a 500000-tick window.
module tachometer_period_and_window_count
    import tach_pkg::*;
#(
    parameter int COUNTER_WIDTH = 32
)
(
    input  logic   clk,
    input  logic   rst_n,
    tach_tick_if.sink     tick,
    tach_result_if.source result,
    tach_cfg_if.sink      cfg
);

    // Configuration registers. Writes are always accepted; an index past the
    // register list is simply dropped.
    measure_mode_t    mode_reg;
    logic [PPR_W-1:0] ppr_reg;
    logic [WIN_W-1:0] window_reg;
    cfg_t             cfg_now;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_PERIOD;
            ppr_reg    <= PPR_RESET;
            window_reg <= WIN_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_MODE:   mode_reg   <= measure_mode_t'(cfg.data[0]);
                CFG_PPR:    ppr_reg    <= cfg.data[PPR_W-1:0];
                CFG_WINDOW: window_reg <= cfg.data[WIN_W-1:0];
                default:    ;
            endcase
        end
    end

    assign cfg_now.measure_mode   = mode_reg;
    assign cfg_now.pulses_per_rev = ppr_reg;
    assign cfg_now.window_us      = window_reg;

    // The front takes a tick whenever the queue has a free entry, because any
    // tick may close a period or a window and so produce a division job.
    logic        tick_accept;
    logic        job_valid;
    job_t        front_job;
    job_t        back_job;
    logic        pop;
    queue_stat_t q_stat;

    assign tick.ready  = !q_stat.full;
    assign tick_accept = tick.valid && tick.ready;

    tach_front #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_now),
        .accept       (tick_accept),
        .sensor_level (tick.sensor_level),
        .job_valid    (job_valid),
        .job          (front_job)
    );

    // The queue decouples the per-tick counters from the long divide, so a
    // result waiting at the output never stops tick counting until the queue fills.
    tach_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_valid),
        .push_job (front_job),
        .pop      (pop),
        .pop_job  (back_job),
        .stat     (q_stat)
    );

    // The back end forms numerator and denominator, then divides one quotient
    // bit per cycle. The result register holds a finished speed while the next
    // job is already being divided.
    tach_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_now),
        .q_stat         (q_stat),
        .q_job          (back_job),
        .pop            (pop),
        .result_valid   (result.valid),
        .result_ready   (result.ready),
        .rpm_hundredths (result.rpm_hundredths),
        .raw_measure    (result.raw_measure)
    );

    // A job is only produced on a tick that was taken while the queue had room.
    assert property (@(posedge clk) disable iff (!rst_n) job_valid |-> !q_stat.full)
        else $error("job pushed into a full queue");

    // The divider only pops an entry that is present.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_stat.valid)
        else $error("job popped from an empty queue");

    // Every delivered speed respects the clamp.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.rpm_hundredths <= RPM_MAX))
        else $error("speed result above clamp");

endmodule
